// ===== rtl/bbs_pkg.sv =====
// Shared types, constants and helpers for the block sorter.
package bbs_pkg;

	localparam int MAX_BLOCK = 16384;
	localparam int IDX_W     = $clog2(MAX_BLOCK);
	localparam int LEN_W     = IDX_W + 1;
	localparam int WIDE_W    = LEN_W + 2;
	localparam int TUPLE_W   = 3 * IDX_W;
	localparam int KEY_W     = 2 * IDX_W;

	typedef logic [IDX_W-1:0]   idx_t;
	typedef logic [LEN_W-1:0]   len_t;
	typedef logic [WIDE_W-1:0]  wide_t;
	typedef logic [TUPLE_W-1:0] tuple_t;
	typedef logic [KEY_W-1:0]   key_t;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_FETCH = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_TRUNC = 2'd2;

	typedef struct packed {
		logic ord_we;
		idx_t ord_waddr;
		idx_t ord_wdata;
		idx_t ord_raddr;
		logic rnk_we;
		idx_t rnk_waddr;
		idx_t rnk_wdata;
		idx_t rnk_raddr_a;
		idx_t rnk_raddr_b;
	} seq_req_t;

	typedef struct packed {
		idx_t ord_rdata;
		idx_t rnk_rdata_a;
		idx_t rnk_rdata_b;
	} seq_rsp_t;

	function automatic wide_t wmin(input wide_t a, input wide_t b);
		return (a < b) ? a : b;
	endfunction

endpackage

// ===== rtl/bbs_ram.sv =====
// Generic RAM: one write port, two registered read ports.
module bbs_ram #(
	parameter int W  = 8,
	parameter int AW = 14
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr_a,
	output logic [W-1:0]  rdata_a,
	input  logic [AW-1:0] raddr_b,
	output logic [W-1:0]  rdata_b
);

	logic [W-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// ===== rtl/bbs_seq.sv =====
// Sort sequencer: prefix doubling rounds of tuple build, merge sort and rank scan.
module bbs_seq import bbs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     go,
	input  len_t     n,
	output logic     done,
	output idx_t     origin,
	output seq_req_t req,
	input  seq_rsp_t rsp
);

	typedef enum logic [7:0] {
		Q_IDLE = 8'b0000_0001,
		Q_PRD0 = 8'b0000_0010,
		Q_PRD1 = 8'b0000_0100,
		Q_PWR  = 8'b0000_1000,
		Q_MRD  = 8'b0001_0000,
		Q_MWR  = 8'b0010_0000,
		Q_SRD  = 8'b0100_0000,
		Q_SWR  = 8'b1000_0000
	} seq_state_t;

	seq_state_t state_q;
	len_t   n_q, r_q, a_q, w_q, i_q, j_q, k_q, mid_q, hi_q;
	idx_t   m_q, s_q, grp_q, origin_q;
	key_t   prev_key_q;
	logic   src_q, dup_q, done_q;

	logic   we_a, we_b;
	idx_t   b_waddr, b_raddr_a, b_raddr_b;
	tuple_t b_wdata;
	tuple_t a_rd_a, a_rd_b, b_rd_a, b_rd_b;
	tuple_t ta, tb;
	logic   take_j;
	len_t   s2_sum, s2;
	wide_t  n_w, a_n, w2, mid_n, hi_n, mid_r, hi_r;
	len_t   r_n, k_n;
	logic   new_grp;
	idx_t   grp_n;

	bbs_ram #(.W(TUPLE_W), .AW(IDX_W)) u_buf_a (
		.clk(clk), .we(we_a), .waddr(b_waddr), .wdata(b_wdata),
		.raddr_a(b_raddr_a), .rdata_a(a_rd_a), .raddr_b(b_raddr_b), .rdata_b(a_rd_b)
	);

	bbs_ram #(.W(TUPLE_W), .AW(IDX_W)) u_buf_b (
		.clk(clk), .we(we_b), .waddr(b_waddr), .wdata(b_wdata),
		.raddr_a(b_raddr_a), .rdata_a(b_rd_a), .raddr_b(b_raddr_b), .rdata_b(b_rd_b)
	);

	assign ta     = src_q ? b_rd_a : a_rd_a;
	assign tb     = src_q ? b_rd_b : a_rd_b;
	assign take_j = (j_q < hi_q) && ((i_q >= mid_q) || (tb < ta));

	assign s2_sum = {1'b0, rsp.ord_rdata} + {1'b0, m_q};
	assign s2     = (s2_sum >= n_q) ? s2_sum - n_q : s2_sum;

	assign n_w   = {2'b00, n_q};
	assign a_n   = {2'b00, a_q} + {1'b0, w_q, 1'b0};
	assign mid_n = wmin(a_n + {2'b00, w_q}, n_w);
	assign hi_n  = wmin(a_n + {1'b0, w_q, 1'b0}, n_w);
	assign w2    = {1'b0, w_q, 1'b0};
	assign mid_r = wmin(w2, n_w);
	assign hi_r  = wmin({w2[WIDE_W-2:0], 1'b0}, n_w);
	assign r_n   = r_q + 1'b1;
	assign k_n   = k_q + 1'b1;

	assign new_grp = (r_q == '0) || (ta[TUPLE_W-1:IDX_W] != prev_key_q);
	assign grp_n   = new_grp ? r_q[IDX_W-1:0] : grp_q;

	always_comb begin
		req       = '0;
		we_a      = 1'b0;
		we_b      = 1'b0;
		b_waddr   = k_q[IDX_W-1:0];
		b_wdata   = take_j ? tb : ta;
		b_raddr_a = i_q[IDX_W-1:0];
		b_raddr_b = j_q[IDX_W-1:0];
		unique case (state_q)
			Q_PRD0: begin
				req.ord_raddr = r_q[IDX_W-1:0];
			end
			Q_PRD1: begin
				req.rnk_raddr_a = rsp.ord_rdata;
				req.rnk_raddr_b = s2[IDX_W-1:0];
			end
			Q_PWR: begin
				we_a    = 1'b1;
				b_waddr = r_q[IDX_W-1:0];
				b_wdata = {rsp.rnk_rdata_a, rsp.rnk_rdata_b, s_q};
			end
			Q_MWR: begin
				we_a = src_q;
				we_b = !src_q;
			end
			Q_SRD: begin
				b_raddr_a = r_q[IDX_W-1:0];
			end
			Q_SWR: begin
				req.rnk_we    = 1'b1;
				req.rnk_waddr = ta[IDX_W-1:0];
				req.rnk_wdata = grp_n;
				req.ord_we    = 1'b1;
				req.ord_waddr = r_q[IDX_W-1:0];
				req.ord_wdata = ta[IDX_W-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= Q_IDLE;
			done_q  <= 1'b0;
			src_q   <= 1'b0;
			dup_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				Q_IDLE: begin
					if (go) begin
						n_q      <= n;
						origin_q <= '0;
						m_q      <= idx_t'(1);
						r_q      <= '0;
						dup_q    <= 1'b0;
						if (n < len_t'(2)) begin
							done_q <= 1'b1;
						end else begin
							state_q <= Q_PRD0;
						end
					end
				end
				Q_PRD0: state_q <= Q_PRD1;
				Q_PRD1: begin
					s_q     <= rsp.ord_rdata;
					state_q <= Q_PWR;
				end
				Q_PWR: begin
					r_q <= r_n;
					if (r_n == n_q) begin
						a_q     <= '0;
						w_q     <= len_t'(1);
						i_q     <= '0;
						mid_q   <= len_t'(1);
						j_q     <= len_t'(1);
						hi_q    <= len_t'(2);
						k_q     <= '0;
						src_q   <= 1'b0;
						state_q <= Q_MRD;
					end else begin
						state_q <= Q_PRD0;
					end
				end
				Q_MRD: state_q <= Q_MWR;
				Q_MWR: begin
					state_q <= Q_MRD;
					if (take_j) begin
						j_q <= j_q + 1'b1;
					end else begin
						i_q <= i_q + 1'b1;
					end
					k_q <= k_n;
					if (k_n == hi_q) begin
						if (a_n >= n_w) begin
							src_q <= !src_q;
							if (w2 >= n_w) begin
								r_q     <= '0;
								dup_q   <= 1'b0;
								state_q <= Q_SRD;
							end else begin
								w_q   <= w2[LEN_W-1:0];
								a_q   <= '0;
								i_q   <= '0;
								k_q   <= '0;
								mid_q <= mid_r[LEN_W-1:0];
								j_q   <= mid_r[LEN_W-1:0];
								hi_q  <= hi_r[LEN_W-1:0];
							end
						end else begin
							a_q   <= a_n[LEN_W-1:0];
							i_q   <= a_n[LEN_W-1:0];
							k_q   <= a_n[LEN_W-1:0];
							mid_q <= mid_n[LEN_W-1:0];
							j_q   <= mid_n[LEN_W-1:0];
							hi_q  <= hi_n[LEN_W-1:0];
						end
					end
				end
				Q_SRD: state_q <= Q_SWR;
				Q_SWR: begin
					prev_key_q <= ta[TUPLE_W-1:IDX_W];
					grp_q      <= grp_n;
					if (ta[IDX_W-1:0] == '0) begin
						origin_q <= r_q[IDX_W-1:0];
					end
					if (!new_grp) begin
						dup_q <= 1'b1;
					end
					r_q <= r_n;
					if (r_n == n_q) begin
						if ((dup_q || !new_grp) && ({m_q, 1'b0} < n_q)) begin
							m_q     <= {m_q[IDX_W-2:0], 1'b0};
							r_q     <= '0;
							state_q <= Q_PRD0;
						end else begin
							done_q  <= 1'b1;
							state_q <= Q_IDLE;
						end
					end else begin
						state_q <= Q_SRD;
					end
				end
				default: state_q <= Q_IDLE;
			endcase
		end
	end

	assign done   = done_q;
	assign origin = origin_q;

	a_merge_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == Q_MWR |-> (k_q < hi_q) && (hi_q <= n_q))
		else $error("merge write outside run");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == Q_IDLE)
		else $error("done while sorting");
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == Q_SWR |-> r_q < n_q)
		else $error("scan past block");

endmodule

// ===== rtl/bwt_block_sort_top.sv =====
// Block sorter top: load bytes, sort all rotations, fetch rows with transform byte.
// A load causes no result; a fetch reads in states T_F1 and T_F2 and then registers its strobe
// (in the cycle after start when no sorted block exists); busy is high in the fetch read states.
// The end-of-block load starts the sort, busy until it ends: each doubling round builds tuples,
// merge sorts them on the shared merge compare unit and scans ranks, at most ceil(log2 n) rounds.
// arst_n clears control state; stored block data is unknown until loaded.
module bwt_block_sort_top import bbs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic       command,
	input  logic [7:0] data_byte,
	input  logic       end_of_block,
	output logic       strobe,
	output logic [7:0] bwt_byte,
	output idx_t       rotation_start,
	output idx_t       original_row,
	output logic       last_row,
	output logic [1:0] status
);

	typedef enum logic [3:0] {
		T_IDLE = 4'b0001,
		T_F1   = 4'b0010,
		T_F2   = 4'b0100,
		T_SORT = 4'b1000
	} top_state_t;

	top_state_t state_q;
	len_t   len_q, fp_q, eff_len, row;
	logic   ready_q, trunc_q, go_q, strobe_q, last_q, last_out_q;
	idx_t   row_q, s_q, prev, start_out_q, orig_out_q;
	logic [7:0] byte_out_q;
	logic [1:0] status_q;
	logic   acc, load, fetch, fetch_ok, load_we;
	logic   seq_done;
	idx_t   origin;
	seq_req_t req;
	seq_rsp_t rsp;
	logic [7:0] byte_rd;
	idx_t   ord_rd_b, byte_unused_b;
	logic [7:0] byte_rd_b;

	assign busy     = (state_q != T_IDLE);
	assign acc      = start && !busy;
	assign load     = acc && (command == CMD_LOAD);
	assign fetch    = acc && (command == CMD_FETCH);
	assign fetch_ok = ready_q && (len_q != '0);
	assign eff_len  = ready_q ? '0 : len_q;
	assign load_we  = load && (eff_len < len_t'(MAX_BLOCK));
	assign row      = (fp_q < len_q) ? fp_q : '0;
	assign prev     = (rsp.ord_rdata == '0) ? idx_t'(len_q - 1'b1) : rsp.ord_rdata - 1'b1;
	assign byte_unused_b = prev;

	bbs_ram #(.W(8), .AW(IDX_W)) u_bytes (
		.clk(clk), .we(load_we), .waddr(eff_len[IDX_W-1:0]), .wdata(data_byte),
		.raddr_a(prev), .rdata_a(byte_rd), .raddr_b(byte_unused_b), .rdata_b(byte_rd_b)
	);

	bbs_ram #(.W(IDX_W), .AW(IDX_W)) u_order (
		.clk(clk), .we(load_we || req.ord_we),
		.waddr(req.ord_we ? req.ord_waddr : eff_len[IDX_W-1:0]),
		.wdata(req.ord_we ? req.ord_wdata : eff_len[IDX_W-1:0]),
		.raddr_a((state_q == T_SORT) ? req.ord_raddr : row[IDX_W-1:0]),
		.rdata_a(rsp.ord_rdata),
		.raddr_b(req.ord_raddr), .rdata_b(ord_rd_b)
	);

	bbs_ram #(.W(IDX_W), .AW(IDX_W)) u_rank (
		.clk(clk), .we(load_we || req.rnk_we),
		.waddr(req.rnk_we ? req.rnk_waddr : eff_len[IDX_W-1:0]),
		.wdata(req.rnk_we ? req.rnk_wdata : {{(IDX_W-8){1'b0}}, data_byte}),
		.raddr_a(req.rnk_raddr_a), .rdata_a(rsp.rnk_rdata_a),
		.raddr_b(req.rnk_raddr_b), .rdata_b(rsp.rnk_rdata_b)
	);

	bbs_seq u_seq (
		.clk(clk), .arst_n(arst_n), .go(go_q), .n(len_q),
		.done(seq_done), .origin(origin), .req(req), .rsp(rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= T_IDLE;
			len_q    <= '0;
			fp_q     <= '0;
			ready_q  <= 1'b0;
			trunc_q  <= 1'b0;
			go_q     <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			go_q     <= 1'b0;
			strobe_q <= 1'b0;
			unique case (state_q)
				T_IDLE: begin
					if (load) begin
						ready_q <= 1'b0;
						if (ready_q) begin
							fp_q <= '0;
						end
						if (eff_len < len_t'(MAX_BLOCK)) begin
							len_q   <= eff_len + 1'b1;
							trunc_q <= ready_q ? 1'b0 : trunc_q;
						end else begin
							len_q   <= eff_len;
							trunc_q <= 1'b1;
						end
						if (end_of_block) begin
							go_q    <= 1'b1;
							fp_q    <= '0;
							state_q <= T_SORT;
						end
					end else if (fetch) begin
						if (fetch_ok) begin
							row_q   <= row[IDX_W-1:0];
							last_q  <= (row == len_q - 1'b1);
							state_q <= T_F1;
						end else begin
							strobe_q    <= 1'b1;
							byte_out_q  <= '0;
							start_out_q <= '0;
							orig_out_q  <= '0;
							last_out_q  <= 1'b0;
							status_q    <= ST_EMPTY;
						end
					end
				end
				T_F1: begin
					s_q     <= rsp.ord_rdata;
					state_q <= T_F2;
				end
				T_F2: begin
					strobe_q    <= 1'b1;
					byte_out_q  <= byte_rd;
					start_out_q <= s_q;
					orig_out_q  <= origin;
					last_out_q  <= last_q;
					status_q    <= trunc_q ? ST_TRUNC : ST_OK;
					fp_q        <= last_q ? '0 : {1'b0, row_q} + 1'b1;
					state_q     <= T_IDLE;
				end
				T_SORT: begin
					if (seq_done) begin
						ready_q <= 1'b1;
						state_q <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	assign strobe         = strobe_q;
	assign bwt_byte       = byte_out_q;
	assign rotation_start = start_out_q;
	assign original_row   = orig_out_q;
	assign last_row       = last_out_q;
	assign status         = status_q;

	a_done_in_sort: assert property (@(posedge clk) disable iff (!arst_n)
		seq_done |-> state_q == T_SORT)
		else $error("sort done outside sort");
	a_len_cap: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= len_t'(MAX_BLOCK))
		else $error("block length over capacity");
	a_ok_needs_block: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && (status_q != ST_EMPTY) |-> ready_q)
		else $error("row given without sorted block");
	a_fetch_path: assert property (@(posedge clk) disable iff (!arst_n)
		fetch && fetch_ok |=> state_q == T_F1)
		else $error("fetch did not start read");

endmodule
